// ===== design/ctsc_pkg.sv =====
// Shared types and constants of the calculator token scanner.
package ctsc_pkg;

    // Longest lexeme run before a token is split
    localparam int MAX_LEXEME = 256;
    localparam int RUN_W      = $clog2(MAX_LEXEME + 1);

    // Depth of the step queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Character codes
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_PIPE   = 8'h7C;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_UC_A   = 8'h41;
    localparam logic [7:0] CH_UC_Z   = 8'h5A;
    localparam logic [7:0] CH_LC_A   = 8'h61;
    localparam logic [7:0] CH_LC_Z   = 8'h7A;

    // Token kinds
    typedef enum logic [3:0] {
        K_INT           = 4'd0,
        K_ID            = 4'd1,
        K_ADDSUB        = 4'd2,
        K_INCDEC        = 4'd3,
        K_ADDSUB_ASSIGN = 4'd4,
        K_MULDIV        = 4'd5,
        K_ASSIGN        = 4'd6,
        K_LPAREN        = 4'd7,
        K_RPAREN        = 4'd8,
        K_AND           = 4'd9,
        K_OR            = 4'd10,
        K_XOR           = 4'd11,
        K_END           = 4'd12,
        K_ENDFILE       = 4'd13,
        K_UNKNOWN       = 4'd14
    } tok_kind_t;

    // Scanner modes
    typedef enum logic [3:0] {
        M_IDLE = 4'b0001,
        M_INT  = 4'b0010,
        M_ID   = 4'b0100,
        M_SIGN = 4'b1000
    } scan_mode_t;

    // One result beat
    typedef struct packed {
        tok_kind_t  kind;
        logic [7:0] ch;
        logic       ch_valid;
        logic       last;
    } tok_res_t;

    // Results of one input item: one or two beats
    typedef struct packed {
        logic     two;
        tok_res_t r1;
        tok_res_t r0;
    } step_rec_t;

endpackage

// ===== design/calculator_token_scanner.sv =====
// Top level of the calculator token scanner.
//
// Channel  Dir  tdata                          tuser              tlast
// s_       in   [7:0] in_char                  -                  end_of_input
// m_       out  [7:0] lexeme_char, [8] char_valid  [3:0] token_kind  token_last
//
// One input beat per cycle while the step queue has room; each item gives zero,
// one or two result beats. The result port sends one beat per cycle while
// m_tready is high; items that give two beats (++, +=, a run or sign closed by a
// single-char token or end of input) use it for both, and the four-record queue
// absorbs short bursts of them.
// Reset is synchronous on aresetn low and empties the queue and scanner state.
// A stall on m_ fills the queue and then drops s_tready; no beat is lost.
module calculator_token_scanner
    import ctsc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_char
    input  logic        s_tlast,   // end_of_input
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] lexeme_char, [8] char_valid, zero above
    output logic [3:0]  m_tuser,   // [3:0] token_kind
    output logic        m_tlast    // token_last
);

    logic      in_accept;
    logic      push, pop, q_not_empty, q_not_full;
    step_rec_t push_rec, head_rec;
    tok_res_t  out_res;

    assign s_tready  = q_not_full;
    assign in_accept = s_tvalid && q_not_full;

    ctsc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .in_char   (s_tdata),
        .in_eoi    (s_tlast),
        .push      (push),
        .push_rec  (push_rec)
    );

    ctsc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_rec  (push_rec),
        .pop       (pop),
        .not_empty (q_not_empty),
        .not_full  (q_not_full),
        .head_rec  (head_rec)
    );

    ctsc_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_head      (head_rec),
        .q_pop       (pop),
        .out_ready   (m_tready),
        .out_valid   (m_tvalid),
        .out_res     (out_res)
    );

    // Pack the result beat
    assign m_tdata = {7'b0, out_res.ch_valid, out_res.ch};
    assign m_tuser = out_res.kind;
    assign m_tlast = out_res.last;

endmodule

// ===== design/ctsc_front.sv =====
// Front end: classifies input characters and builds the results of each item.
module ctsc_front
    import ctsc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_accept,
    input  logic [7:0] in_char,
    input  logic       in_eoi,
    output logic       push,
    output step_rec_t  push_rec
);

    scan_mode_t       mode_reg, mode_next;
    logic [7:0]       held_reg, held_next;
    logic [RUN_W-1:0] run_reg, run_next;

    logic      is_digit, is_letter;
    logic      cont, done;
    logic [1:0] n;
    tok_res_t  r0, r1, st;
    logic      st_put;

    assign is_digit  = (in_char inside {[CH_0:CH_9]});
    assign is_letter = (in_char inside {[CH_UC_A:CH_UC_Z], [CH_LC_A:CH_LC_Z]});

    // Work out results and next state for the item on the input
    always_comb begin
        mode_next = mode_reg;
        held_next = held_reg;
        run_next  = run_reg;
        n         = 2'd0;
        done      = 1'b0;
        cont      = 1'b0;
        r0        = '{kind: K_UNKNOWN, ch: 8'h00, ch_valid: 1'b0, last: 1'b1};
        r1        = r0;
        st        = r0;
        st_put    = 1'b0;

        // Close or extend the pending run or sign
        case (mode_reg)
            M_INT, M_ID: begin
                cont = !in_eoi && ((mode_reg == M_INT) ? is_digit : is_letter);
                r0.kind     = (mode_reg == M_INT) ? K_INT : K_ID;
                r0.ch       = held_reg;
                r0.ch_valid = 1'b1;
                n           = 2'd1;
                if (cont && (run_reg < RUN_W'(MAX_LEXEME))) begin
                    r0.last   = 1'b0;
                    held_next = in_char;
                    run_next  = run_reg + RUN_W'(1);
                    done      = 1'b1;
                end else begin
                    r0.last   = 1'b1;
                    mode_next = M_IDLE;
                    run_next  = '0;
                end
            end
            M_SIGN: begin
                r0.ch       = held_reg;
                r0.ch_valid = 1'b1;
                n           = 2'd1;
                mode_next   = M_IDLE;
                run_next    = '0;
                if (!in_eoi && ((in_char == held_reg) || (in_char == CH_EQ))) begin
                    r0.kind     = (in_char == held_reg) ? K_INCDEC : K_ADDSUB_ASSIGN;
                    r0.last     = 1'b0;
                    r1.kind     = r0.kind;
                    r1.ch       = in_char;
                    r1.ch_valid = 1'b1;
                    r1.last     = 1'b1;
                    n           = 2'd2;
                    done        = 1'b1;
                end else begin
                    r0.kind = K_ADDSUB;
                    r0.last = 1'b1;
                end
            end
            default: begin
            end
        endcase

        // Start a new token from the current character, or end the stream
        if (!done) begin
            if (in_eoi) begin
                st.kind   = K_ENDFILE;
                st_put    = 1'b1;
                mode_next = M_IDLE;
                run_next  = '0;
            end else if (is_digit || is_letter || (in_char inside {CH_PLUS, CH_MINUS})) begin
                mode_next = is_digit ? M_INT : (is_letter ? M_ID : M_SIGN);
                held_next = in_char;
                run_next  = RUN_W'(1);
            end else if (!(in_char inside {CH_SPACE, CH_TAB})) begin
                st_put = 1'b1;
                case (in_char)
                    CH_STAR, CH_SLASH: st = '{K_MULDIV, in_char, 1'b1, 1'b1};
                    CH_EQ:             st = '{K_ASSIGN, in_char, 1'b1, 1'b1};
                    CH_LPAREN:         st = '{K_LPAREN, in_char, 1'b1, 1'b1};
                    CH_RPAREN:         st = '{K_RPAREN, in_char, 1'b1, 1'b1};
                    CH_NL:             st.kind = K_END;
                    CH_AMP:            st.kind = K_AND;
                    CH_PIPE:           st.kind = K_OR;
                    CH_CARET:          st.kind = K_XOR;
                    default:           st.kind = K_UNKNOWN;
                endcase
            end
            if (st_put) begin
                if (n == 2'd0) begin
                    r0 = st;
                end else begin
                    r1 = st;
                end
                n = n + 2'd1;
            end
        end
    end

    assign push         = in_accept && (n != 2'd0);
    assign push_rec.two = (n == 2'd2);
    assign push_rec.r0  = r0;
    assign push_rec.r1  = r1;

    // Advance scanner state on each accepted beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= M_IDLE;
            held_reg <= 8'h00;
            run_reg  <= '0;
        end else if (in_accept) begin
            mode_reg <= mode_next;
            held_reg <= held_next;
            run_reg  <= run_next;
        end
    end

endmodule

// ===== design/ctsc_queue.sv =====
// Short queue of step records between the front and back ends.
module ctsc_queue
    import ctsc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  step_rec_t push_rec,
    input  logic      pop,
    output logic      not_empty,
    output logic      not_full,
    output step_rec_t head_rec
);

    step_rec_t         slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign not_empty = (count_reg != '0);
    assign not_full  = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign head_rec  = slot_reg[rd_ptr_reg];

    // Store pushed records
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_rec;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + QCNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

endmodule

// ===== design/ctsc_back.sv =====
// Back end: holds a step record in the output register and sends its beats.
module ctsc_back
    import ctsc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      q_not_empty,
    input  step_rec_t q_head,
    output logic      q_pop,
    input  logic      out_ready,
    output logic      out_valid,
    output tok_res_t  out_res
);

    step_rec_t rec_reg;
    logic      valid_reg;
    logic      half_reg;
    logic      final_beat;

    assign final_beat = half_reg || !rec_reg.two;
    assign q_pop      = q_not_empty && (!valid_reg || (out_ready && final_beat));
    assign out_valid  = valid_reg;
    assign out_res    = half_reg ? rec_reg.r1 : rec_reg.r0;

    // Load the next record, step to its second beat, or go empty after the final beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            half_reg  <= 1'b0;
        end else if (q_pop) begin
            valid_reg <= 1'b1;
            half_reg  <= 1'b0;
        end else if (valid_reg && out_ready) begin
            if (final_beat) begin
                valid_reg <= 1'b0;
                half_reg  <= 1'b0;
            end else begin
                half_reg <= 1'b1;
            end
        end
    end

    // Hold the record payload
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            rec_reg <= q_head;
        end
    end

endmodule

// ===== design/ctsc_checker.sv =====
// Port checker for the calculator token scanner, bound to the top level.
module ctsc_checker
    import ctsc_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [3:0]  m_tuser,
    input logic        m_tlast
);

    // Hold a stalled input beat unchanged
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tlast))
        else $error("input beat changed while stalled");

    // Keep a stalled result beat valid
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    // Character-less beats carry a zero character and are last
    a_empty_char: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[8] |-> (m_tdata[7:0] == 8'h00) && m_tlast)
        else $error("character-less beat with data or not last");

    // End of stream is a single character-less beat
    a_endfile: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == K_ENDFILE) |-> !m_tdata[8] && m_tlast)
        else $error("endfile beat malformed");

    // Padding bits of the result stay zero
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[15:9] == 7'b0))
        else $error("result padding not zero");

endmodule

bind calculator_token_scanner ctsc_checker u_ctsc_checker (.*);
